>>> rtl/ssd_pkg.sv
// shared types and constants for the searchable stack
package ssd_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int VAL_W           = 32;
	localparam int POS_W           = 4;
	localparam int DEPTH_W         = 5;

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_SEARCH  = 2'd1,
		OP_DELETE  = 2'd2,
		OP_DISPLAY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

endpackage

>>> rtl/ssd_if.sv
// command and response channel interfaces of the searchable stack
interface ssd_cmd_if;
	import ssd_pkg::*;
	logic                     valid;
	logic                     ready;
	op_t                      op;
	logic signed [VAL_W-1:0]  value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

interface ssd_rsp_if;
	import ssd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [VAL_W-1:0]  value_out;
	logic [POS_W-1:0]         position;
	status_t                  status;
	logic [DEPTH_W-1:0]       depth_now;
	logic                     last;

	modport source (output valid, output value_out, output position, output status,
		output depth_now, output last, input ready);
	modport sink   (input valid, input value_out, input position, input status,
		input depth_now, input last, output ready);
endinterface

>>> rtl/ssd_ram.sv
// generic single write port ram with registered read
module ssd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/searchable_stack_with_delete_unit.sv
// searchable stack with delete: sequencer around one compare and one two-port ram
//
//   channel | role | handshake   | payload
//   cmd     | sink | valid/ready | op, value
//   rsp     | src  | valid/ready | value_out, position, status, depth_now, last
//
// push: write, then result; search: read, compare per entry from the top;
// delete adds read, write per moved entry; display: read, load, show per entry.
// all entries go through the single read port of the stack ram, one a step.
// reset clears the count and all registers; the ram contents are not cleared.
// cmd is not ready from acceptance until the final result item is taken;
// a result holds in rsp while ready is low.
module searchable_stack_with_delete_unit #(
	parameter int STACK_DEPTH = ssd_pkg::STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ssd_cmd_if.sink   cmd,
	ssd_rsp_if.source rsp
);
	import ssd_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHF_RD,
		S_SHF_WR,
		S_DISP_RD,
		S_DISP_LD,
		S_OUT
	} state_t;

	state_t                  state_q;
	op_t                     op_q;
	logic [VAL_W-1:0]        val_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           addr_q;
	logic [POS_W-1:0]        k_q;
	logic [VAL_W-1:0]        vo_q;
	logic [POS_W-1:0]        pos_q;
	status_t                 st_q;
	logic                    last_q;

	logic                    we;
	logic [AW-1:0]           waddr;
	logic [VAL_W-1:0]        wdata;
	logic [AW-1:0]           raddr;
	logic [VAL_W-1:0]        rdata;

	ssd_ram #(
		.WIDTH (VAL_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cmd.ready     = (state_q == S_IDLE);
	assign rsp.valid     = (state_q == S_OUT);
	assign rsp.value_out = vo_q;
	assign rsp.position  = pos_q;
	assign rsp.status    = st_q;
	assign rsp.depth_now = DEPTH_W'(count_q);
	assign rsp.last      = last_q;

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = rdata;
		raddr = addr_q;
		unique case (state_q)
			S_PUSH: begin
				waddr = AW'(count_q);
				wdata = val_q;
				we    = (int'(count_q) < STACK_DEPTH);
			end
			S_SHF_RD: begin
				raddr = AW'(addr_q + 1'b1);
			end
			S_SHF_WR: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_PUSH;
			val_q   <= '0;
			count_q <= '0;
			addr_q  <= '0;
			k_q     <= '0;
			vo_q    <= '0;
			pos_q   <= '0;
			st_q    <= ST_OK;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q   <= cmd.op;
						val_q  <= cmd.value;
						addr_q <= AW'(count_q - 1'b1);
						k_q    <= '0;
						vo_q   <= '0;
						pos_q  <= '0;
						last_q <= 1'b1;
						if (cmd.op == OP_PUSH) begin
							state_q <= S_PUSH;
						end else if (count_q == '0) begin
							st_q    <= ST_EMPTY;
							state_q <= S_OUT;
						end else if (cmd.op == OP_DISPLAY) begin
							state_q <= S_DISP_RD;
						end else begin
							state_q <= S_SRCH_RD;
						end
					end
				end
				S_PUSH: begin
					vo_q   <= val_q;
					pos_q  <= '0;
					last_q <= 1'b1;
					if (int'(count_q) < STACK_DEPTH) begin
						count_q <= count_q + 1'b1;
						st_q    <= ST_OK;
					end else begin
						st_q <= ST_FULL;
					end
					state_q <= S_OUT;
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					if (rdata == val_q) begin
						vo_q   <= rdata;
						pos_q  <= POS_W'(int'(count_q) - 1 - int'(addr_q));
						st_q   <= ST_OK;
						last_q <= 1'b1;
						if (op_q != OP_DELETE) begin
							state_q <= S_OUT;
						end else if (int'(addr_q) + 1 == int'(count_q)) begin
							// top entry removed, nothing to close up
							count_q <= count_q - 1'b1;
							state_q <= S_OUT;
						end else begin
							state_q <= S_SHF_RD;
						end
					end else if (addr_q == '0) begin
						vo_q    <= '0;
						pos_q   <= '0;
						st_q    <= ST_NOT_FOUND;
						last_q  <= 1'b1;
						state_q <= S_OUT;
					end else begin
						addr_q  <= addr_q - 1'b1;
						state_q <= S_SRCH_RD;
					end
				end
				S_SHF_RD: begin
					state_q <= S_SHF_WR;
				end
				S_SHF_WR: begin
					if (int'(addr_q) + 2 < int'(count_q)) begin
						addr_q  <= addr_q + 1'b1;
						state_q <= S_SHF_RD;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_OUT;
					end
				end
				S_DISP_RD: begin
					state_q <= S_DISP_LD;
				end
				S_DISP_LD: begin
					vo_q    <= rdata;
					pos_q   <= k_q;
					st_q    <= ST_OK;
					last_q  <= (int'(k_q) + 1 == int'(count_q)) ||
						(k_q == POS_W'(MAX_RESULTS - 1));
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) begin
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							addr_q  <= addr_q - 1'b1;
							state_q <= S_DISP_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

>>> rtl/ssd_checker.sv
// port level checks for the searchable stack, bound to the top level
module ssd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [ssd_pkg::VAL_W-1:0]   rsp_value_out,
	input ssd_pkg::status_t            rsp_status,
	input logic                        rsp_last
);
	import ssd_pkg::*;

	// one item in flight: no new command while a result is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !cmd_ready)
		else $error("cmd ready while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("cmd ready right after an accepted item");

	// more results follow a non-final one before a new command is taken
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready && !rsp_last) |=> !cmd_ready)
		else $error("cmd ready before the final result");

	a_partial_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_last) |-> (rsp_status == ST_OK))
		else $error("non-final result with error status");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value_out)))
		else $error("stalled result changed");
endmodule

bind searchable_stack_with_delete_unit ssd_checker u_ssd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_value_out (rsp.value_out),
	.rsp_status    (rsp.status),
	.rsp_last      (rsp.last)
);
